### rtl/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder: queue entry type, surrogate
// constants and the length and byte encoder functions. No dependencies.
package u16u8_pkg;

  localparam logic [15:0] HighFirst = 16'hd800;
  localparam logic [15:0] HighLast  = 16'hdbff;
  localparam logic [15:0] LowFirst  = 16'hdc00;
  localparam logic [15:0] LowLast   = 16'hdfff;
  localparam logic [20:0] SuppBase  = 21'h10000;

  localparam logic [7:0] ContMark  = 8'h80;
  localparam logic [7:0] Lead2Mark = 8'hc0;
  localparam logic [7:0] Lead3Mark = 8'he0;
  localparam logic [7:0] Lead4Mark = 8'hf0;

  // One queued job: an optional held surrogate sent alone (three bytes),
  // followed by an optional code point of one to four bytes.
  typedef struct packed {
    logic        has_a;
    logic [9:0]  a_bits;
    logic        has_b;
    logic [20:0] b_cp;
    logic [2:0]  b_len;
    logic        last;
  } job_t;

  function automatic logic [2:0] enc_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h80) begin
      len = 3'd1;
    end else if (cp < 21'h800) begin
      len = 3'd2;
    end else if (cp < SuppBase) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte k of the UTF-8 sequence of length len for code point cp.
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [1:0] k);
    logic [7:0] b;
    logic [2:0] rem;
    rem = len - 3'd1 - {1'b0, k};
    b = 8'h00;
    if (k == 2'd0) begin
      case (len)
        3'd1:    b = {1'b0, cp[6:0]};
        3'd2:    b = Lead2Mark | {3'b000, cp[10:6]};
        3'd3:    b = Lead3Mark | {4'h0, cp[15:12]};
        default: b = Lead4Mark | {5'b00000, cp[20:18]};
      endcase
    end else begin
      case (rem)
        3'd0:    b = ContMark | {2'b00, cp[5:0]};
        3'd1:    b = ContMark | {2'b00, cp[11:6]};
        default: b = ContMark | {2'b00, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

### rtl/u16u8_if.sv
// Channel interfaces of the transcoder: UTF-16 unit input and UTF-8 byte
// output, each with valid/ready handshake. No dependencies.
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_end;

  modport source (output valid, output code_unit, output string_end, input ready);
  modport sink   (input valid, input code_unit, input string_end, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output utf8_byte, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input utf8_byte, input run_last, input string_done,
                  output ready);
endinterface

### rtl/u16u8_front.sv
// Front end: accepts code units, tracks a held high surrogate and builds jobs.
// Depends on u16u8_pkg.
module u16u8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [15:0]       code_unit_i,
  input  logic              string_end_i,
  input  logic              q_full_i,
  output logic              in_ready_o,
  output logic              push_o,
  output u16u8_pkg::job_t   job_o
);
  import u16u8_pkg::*;

  logic       held_q, held_d;
  logic [9:0] hbits_q, hbits_d;
  logic       is_high, is_low, take;
  logic [20:0] pair_cp;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign is_high    = (code_unit_i >= HighFirst) && (code_unit_i <= HighLast);
  assign is_low     = (code_unit_i >= LowFirst) && (code_unit_i <= LowLast);
  assign pair_cp    = SuppBase + {1'b0, hbits_q, code_unit_i[9:0]};

  always_comb begin
    held_d  = held_q;
    hbits_d = hbits_q;
    job_o   = '0;
    job_o.last = string_end_i;
    push_o  = 1'b0;
    if (take) begin
      if (held_q && is_low) begin
        held_d      = 1'b0;
        job_o.has_b = 1'b1;
        job_o.b_cp  = pair_cp;
        job_o.b_len = 3'd4;
        push_o      = 1'b1;
      end else begin
        job_o.has_a  = held_q;
        job_o.a_bits = hbits_q;
        if (is_high && !string_end_i) begin
          held_d  = 1'b1;
          hbits_d = code_unit_i[9:0];
          push_o  = held_q;
        end else begin
          held_d      = 1'b0;
          job_o.has_b = 1'b1;
          job_o.b_cp  = {5'b00000, code_unit_i};
          job_o.b_len = enc_len({5'b00000, code_unit_i});
          push_o      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      hbits_q <= '0;
    end else begin
      held_q  <= held_d;
      hbits_q <= hbits_d;
    end
  end

endmodule

### rtl/u16u8_fifo.sv
// Small job queue between front and back end. Depends on u16u8_pkg.
module u16u8_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16u8_pkg::job_t push_job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output u16u8_pkg::job_t head_o
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/u16u8_back.sv
// Back end: walks the head job byte by byte into a registered output stage.
// Depends on u16u8_pkg.
module u16u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  u16u8_pkg::job_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      utf8_byte_o,
  output logic            run_last_o,
  output logic            string_done_o
);
  import u16u8_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       rlast_q, rlast_d, sdone_q, sdone_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] total, kb;
  logic       advance, in_a, final_byte;

  assign total      = (head_i.has_a ? 3'd3 : 3'd0) + (head_i.has_b ? head_i.b_len : 3'd0);
  assign in_a       = head_i.has_a && (idx_q < 3'd3);
  assign kb         = idx_q - (head_i.has_a ? 3'd3 : 3'd0);
  assign final_byte = (idx_q == total - 3'd1);
  assign advance    = !empty_i && (!vld_q || out_ready_i);
  assign pop_o      = advance && final_byte;

  always_comb begin
    vld_d   = vld_q && !out_ready_i;
    byte_d  = byte_q;
    rlast_d = rlast_q;
    sdone_d = sdone_q;
    idx_d   = idx_q;
    if (advance) begin
      vld_d = 1'b1;
      if (in_a) begin
        byte_d = enc_byte({5'b00000, 6'b110110, head_i.a_bits}, 3'd3, idx_q[1:0]);
      end else begin
        byte_d = enc_byte(head_i.b_cp, head_i.b_len, kb[1:0]);
      end
      rlast_d = final_byte;
      sdone_d = final_byte && head_i.last;
      idx_d   = final_byte ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    rlast_q <= rlast_d;
    sdone_q <= sdone_d;
  end

  assign out_valid_o   = vld_q;
  assign utf8_byte_o   = byte_q;
  assign run_last_o    = rlast_q;
  assign string_done_o = sdone_q;

endmodule

### rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder. The front end takes one code unit per cycle while
// its job queue has room; a high surrogate that is not the last unit of its
// string is held, and a following low surrogate joins it into one four-byte
// sequence, otherwise the held surrogate goes out alone as three bytes. The back
// end sends one byte per cycle through a registered output stage while the
// receiver is ready; an item causes one to four bytes for a unit on its
// own, three to six when a held surrogate is flushed ahead of it, none when a
// surrogate is only held. The single-byte output port sets the sustained rate; the
// queue of FifoDepth jobs lets input keep flowing while the output stalls or drains.
// run_last marks the last byte of an item, string_done the last byte of a string.
// Depends on u16u8_pkg, u16u8_if, u16u8_front, u16u8_fifo and u16u8_back.
module utf16_to_utf8_transcoder_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  u16u8_in_if.sink            in_i,
  u16u8_out_if.source         out_o
);
  import u16u8_pkg::*;

  logic push, pop, full, empty;
  job_t push_job, head_job;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .code_unit_i (in_i.code_unit),
    .string_end_i(in_i.string_end),
    .q_full_i    (full),
    .in_ready_o  (in_i.ready),
    .push_o      (push),
    .job_o       (push_job)
  );

  u16u8_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .full_o    (full),
    .empty_o   (empty),
    .head_o    (head_job)
  );

  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .utf8_byte_o  (out_o.utf8_byte),
    .run_last_o   (out_o.run_last),
    .string_done_o(out_o.string_done)
  );

endmodule

### sim/utf8_encode_monitor.sv
`timescale 1ns / 100ps
// Watches both channels of the transcoder, predicts the UTF-8 bytes of every
// accepted code unit and compares them with the bytes that come out.
// Depends on u16u8_pkg and u16u8_if.
module utf8_encode_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  u16u8_in_if         in_mon,
  u16u8_out_if        out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  import u16u8_pkg::*;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       string_done;
  } utf8_res_t;

  utf8_res_t  want_q[$];
  logic [7:0] item_bytes[$];
  logic       held_q;
  logic [9:0] held_bits_q;

  task automatic report_mismatch(input string what, input utf8_res_t got, input utf8_res_t want);
    $display("%0t mismatch (%s): got %02h/%0b/%0b want %02h/%0b/%0b", $realtime, what,
             got.utf8_byte, got.run_last, got.string_done,
             want.utf8_byte, want.run_last, want.string_done);
    fail_cnt_o = fail_cnt_o + 1;
  endtask

  // Adds one byte at the end of the bytes of the current item.
  task automatic add_byte(input logic [7:0] b);
    item_bytes.insert(item_bytes.size(), b);
  endtask

  // Appends the UTF-8 bytes of one code point to the bytes of the current item.
  task automatic push_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      add_byte(8'hc0 | {3'd0, cp[10:6]});
      add_byte(8'h80 | {2'd0, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte(8'he0 | {4'd0, cp[15:12]});
      add_byte(8'h80 | {2'd0, cp[11:6]});
      add_byte(8'h80 | {2'd0, cp[5:0]});
    end else begin
      add_byte(8'hf0 | {5'd0, cp[20:18]});
      add_byte(8'h80 | {2'd0, cp[17:12]});
      add_byte(8'h80 | {2'd0, cp[11:6]});
      add_byte(8'h80 | {2'd0, cp[5:0]});
    end
  endtask

  task automatic predict_unit(input logic [15:0] unit, input logic last);
    logic        is_high;
    logic        is_low;
    logic        paired;
    logic [20:0] cp;
    utf8_res_t   r;
    int          i;
    is_high = (unit >= HighFirst) && (unit <= HighLast);
    is_low  = (unit >= LowFirst) && (unit <= LowLast);
    paired  = 1'b0;
    item_bytes.delete();
    if (held_q) begin
      held_q = 1'b0;
      if (is_low) begin
        // A held high surrogate and a low one form a supplementary code point.
        cp = SuppBase + {1'b0, held_bits_q, 10'd0} + {11'd0, unit[9:0]};
        push_point(cp);
        paired = 1'b1;
      end else begin
        push_point({5'd0, HighFirst | {6'd0, held_bits_q}});
      end
    end
    if (!paired) begin
      if (is_high && !last) begin
        held_q      = 1'b1;
        held_bits_q = unit[9:0];
      end else begin
        push_point({5'd0, unit});
      end
    end
    for (i = 0; i < item_bytes.size(); i++) begin
      r.utf8_byte   = item_bytes[i];
      r.run_last    = (i == item_bytes.size() - 1);
      r.string_done = r.run_last && last;
      want_q.insert(want_q.size(), r);
    end
  endtask

  always @(posedge clk_i) begin
    utf8_res_t got;
    utf8_res_t want;
    if (!rst_ni) begin
      held_q      = 1'b0;
      held_bits_q = '0;
      want_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_unit(in_mon.code_unit, in_mon.string_end);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.utf8_byte, out_mon.run_last, out_mon.string_done};
        if (want_q.size() == 0) begin
          report_mismatch("byte with nothing predicted", got, '0);
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            report_mismatch("field differs", got, want);
          end
        end
      end
    end
    pending_o = want_q.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Top of the transcoder testbench: clock, reset, code unit stimulus and the
// receiver's ready. Depends on u16u8_pkg, u16u8_if, the transcoder and the monitor.
module tb;
  import u16u8_pkg::*;

  // The run ends here at the latest; far beyond the slowest correct run.
  localparam int LimitNs    = 400000;
  // Length of the single long hold-off of the receiver, in cycles.
  localparam int HoldCycles = 400;

  logic        clk;
  logic        rst_n;
  int unsigned fail_cnt;
  int unsigned pending;

  // Idling percentages of the sender and the receiver for the current phase.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  // The stimulus asks for one long hold-off; the receiver process serves it.
  bit          hold_req;
  bit          hold_served;

  u16u8_in_if  in_ch ();
  u16u8_out_if out_ch ();

  utf16_to_utf8_transcoder_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  utf8_encode_monitor u_mon (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LimitNs);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver. Ready is redrawn every cycle outside a hold-off; when one is requested,
  // ready stays low for the length that HoldCycles gives, counted here, while the
  // sender keeps offering units so that the job queue fills and the input stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_served = 1'b1;
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offers one code unit and returns at the edge where it is transferred.
  // Valid is left high, so the next call in the same step either brings new
  // data or lowers valid for an idle cycle; it is never lowered and raised in
  // one step.
  task automatic send_unit(input logic [15:0] unit, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.code_unit  <= unit;
    in_ch.string_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Lowers valid and waits until every predicted byte has been transferred.
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random traffic. Surrogate pairs make up a large share so that the holding
  // state is entered often; the rest is plain BMP text, lone surrogates and
  // raw 16-bit noise.
  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input int n_items);
    int          sent;
    int unsigned pick;
    logic [15:0] unit;
    sent         = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        unit = 16'($urandom_range(16'h007f));
      end else if (pick < 35) begin
        unit = 16'($urandom_range(16'h07ff, 16'h0080));
      end else if (pick < 50) begin
        unit = 16'($urandom_range(16'hffff, 16'h0800));
      end else if (pick < 80) begin
        // Well-formed pair; now and then the high half wrongly ends the string.
        send_unit(16'($urandom_range(HighLast, HighFirst)), ($urandom_range(11) == 0));
        sent++;
        unit = 16'($urandom_range(LowLast, LowFirst));
      end else if (pick < 88) begin
        unit = 16'($urandom_range(HighLast, HighFirst));
      end else if (pick < 94) begin
        unit = 16'($urandom_range(LowLast, LowFirst));
      end else begin
        unit = 16'($urandom_range(16'hffff));
      end
      send_unit(unit, ($urandom_range(5) == 0));
      sent++;
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.code_unit  = '0;
    in_ch.string_end = 1'b0;
    hold_req         = 1'b0;
    src_idle_pct     = 27;
    snk_idle_pct     = 77;
    rst_n            = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: encoding length boundaries, then the surrogate cases.
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007f, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07ff, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hffff, 1'b1);
    // Smallest and largest supplementary code points; the second pair ends a string.
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdbff, 1'b0);
    send_unit(16'hdfff, 1'b1);
    // Held surrogate flushed by an ASCII unit, then by a three-byte unit.
    send_unit(16'hd834, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hd800, 1'b0);
    send_unit(16'hffff, 1'b0);
    // Held surrogate replaced by another high one, which then pairs.
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdbff, 1'b0);
    send_unit(16'hdc00, 1'b0);
    // High surrogate as the last unit of a string is sent, not held.
    send_unit(16'hdbff, 1'b1);
    // Lone low surrogates.
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdfff, 1'b1);
    // Held surrogate, then a high one that ends the string.
    send_unit(16'hd801, 1'b0);
    send_unit(16'hd800, 1'b1);
    // Held surrogate, then a NUL or a BMP unit that ends the string.
    send_unit(16'hda55, 1'b0);
    send_unit(16'h0000, 1'b1);
    send_unit(16'hd9ab, 1'b0);
    send_unit(16'h1234, 1'b1);
    drain_outputs();

    run_phase(27, 77, 45);
    drain_outputs();
    run_phase(77, 27, 45);
    // The sender pauses here until every predicted byte has arrived.
    drain_outputs();

    // No idling on either side, apart from the one long hold-off of the receiver.
    hold_req = 1'b1;
    run_phase(0, 0, 45);
    drain_outputs();

    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
